>>> rtl/bdq_pkg.sv
// Package for the bounded double-ended queue: sizes, request and status codes,
// and the command bundle passed from the controller to the datapath.
// Depends on nothing; bdq_ctrl, bdq_datapath, the top level and the testbench import it.
`timescale 1ns / 1ps

package bdq_pkg;

   // Queue depth. The ring wraps by truncating the index, so it is a power of two.
   localparam int DEPTH     = 64;
   localparam int WORD_BITS = 32;
   localparam int IDX_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   localparam logic [1:0] REQ_PUSH_BACK  = 2'd0;
   localparam logic [1:0] REQ_POP_BACK   = 2'd1;
   localparam logic [1:0] REQ_PUSH_FRONT = 2'd2;
   localparam logic [1:0] REQ_POP_FRONT  = 2'd3;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_EMPTY_POP = 2'd2;

   typedef struct packed {
      logic accept;   // capture the request on this edge
      logic access;   // perform the ring access and pointer update
      logic finish;   // load the result registers
   } bdq_cmd_type;

endpackage

>>> rtl/bdq_ram.sv
// Generic single-port RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/bdq_ctrl.sv
// Controller state machine of the queue: sequences capture, ring access and result.
// Depends on bdq_pkg.
`timescale 1ns / 1ps

module bdq_ctrl import bdq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output bdq_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      access_ff;
   logic      finish_ff;
   logic      accept;

   assign accept = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         busy_ff   <= 1'b0;
         access_ff <= 1'b0;
         finish_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff  <= ST_ACCESS;
                  busy_ff   <= 1'b1;
                  access_ff <= 1'b1;
               end
            end
            ST_ACCESS: begin
               state_ff  <= ST_FINISH;
               access_ff <= 1'b0;
               finish_ff <= 1'b1;
            end
            ST_FINISH: begin
               state_ff  <= ST_IDLE;
               finish_ff <= 1'b0;
               busy_ff   <= 1'b0;
            end
            default: begin
               state_ff  <= ST_IDLE;
               busy_ff   <= 1'b0;
               access_ff <= 1'b0;
               finish_ff <= 1'b0;
            end
         endcase
      end
   end

   assign busy       = busy_ff;
   assign cmd.accept = accept;
   assign cmd.access = access_ff;
   assign cmd.finish = finish_ff;

endmodule

>>> rtl/bdq_datapath.sv
// Datapath of the queue: request registers, ring pointers, word store and result registers.
// Depends on bdq_pkg and bdq_ram.
`timescale 1ns / 1ps

module bdq_datapath import bdq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  bdq_cmd_type         cmd,
   input  logic [1:0]          req_type,
   input  logic [WORD_BITS-1:0] req_item_value,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic [WORD_BITS-1:0] rsp_popped_value,
   output logic [CNT_BITS-1:0] rsp_fill_count,
   output logic                rsp_is_empty,
   output logic                rsp_is_full
);

   logic [1:0]           type_ff;
   logic [WORD_BITS-1:0] value_ff;
   logic [IDX_BITS-1:0]  front_ff, front_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [1:0]           status_ff, status_in;
   logic                 popped_ff, popped_in;
   logic                 valid_ff;
   logic [1:0]           out_status_ff;
   logic [WORD_BITS-1:0] out_value_ff;
   logic [CNT_BITS-1:0]  out_count_ff;
   logic                 out_empty_ff;
   logic                 out_full_ff;

   logic                 is_push, is_full, is_empty, ok;
   logic [IDX_BITS-1:0]  count_idx, addr;
   logic                 wr_en, rd_en;
   logic [WORD_BITS-1:0] rdata;

   assign is_push   = (type_ff == REQ_PUSH_BACK) || (type_ff == REQ_PUSH_FRONT);
   assign is_full   = (count_ff == CNT_BITS'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign ok        = is_push ? !is_full : !is_empty;
   assign count_idx = count_ff[IDX_BITS-1:0];

   always_comb begin
      addr      = front_ff;
      front_in  = front_ff;
      count_in  = count_ff;
      status_in = STATUS_DONE;
      popped_in = 1'b0;
      case (type_ff)
         REQ_PUSH_BACK: begin
            addr = front_ff + count_idx;
            if (ok) begin
               count_in = count_ff + 1'b1;
            end else begin
               status_in = STATUS_FULL;
            end
         end
         REQ_PUSH_FRONT: begin
            addr = front_ff - 1'b1;
            if (ok) begin
               front_in = front_ff - 1'b1;
               count_in = count_ff + 1'b1;
            end else begin
               status_in = STATUS_FULL;
            end
         end
         REQ_POP_BACK: begin
            addr = front_ff + count_idx - 1'b1;
            if (ok) begin
               count_in  = count_ff - 1'b1;
               popped_in = 1'b1;
            end else begin
               status_in = STATUS_EMPTY_POP;
            end
         end
         REQ_POP_FRONT: begin
            addr = front_ff;
            if (ok) begin
               front_in  = front_ff + 1'b1;
               count_in  = count_ff - 1'b1;
               popped_in = 1'b1;
            end else begin
               status_in = STATUS_EMPTY_POP;
            end
         end
         default: begin
            addr = front_ff;
         end
      endcase
   end

   assign wr_en = cmd.access && is_push && ok;
   assign rd_en = cmd.access && !is_push;

   bdq_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .wr_en (wr_en),
      .rd_en (rd_en),
      .addr  (addr),
      .wdata (value_ff),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.finish;
         if (cmd.access) begin
            front_ff <= front_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         type_ff  <= req_type;
         value_ff <= req_item_value;
      end
      if (cmd.access) begin
         status_ff <= status_in;
         popped_ff <= popped_in;
      end
      if (cmd.finish) begin
         out_status_ff <= status_ff;
         out_value_ff  <= popped_ff ? rdata : '0;
         out_count_ff  <= count_ff;
         out_empty_ff  <= is_empty;
         out_full_ff   <= is_full;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_popped_value = out_value_ff;
   assign rsp_fill_count   = out_count_ff;
   assign rsp_is_empty     = out_empty_ff;
   assign rsp_is_full      = out_full_ff;

endmodule

>>> rtl/bounded_double_ended_queue_core.sv
// Top level of the bounded double-ended queue of words, kept as a ring in a RAM.
// Depends on bdq_pkg, bdq_ctrl, bdq_datapath and bdq_ram.
`timescale 1ns / 1ps

// A request is taken at a rising edge where start is high and busy is low. It
// pushes a word at the back or front, or pops one from the back or front, and
// always yields exactly one result: rsp_valid is high for a single cycle, and
// the receiver cannot stall it, so the result must be captured in that cycle.
// A request is handled in order: it is captured, the single access to the word
// store RAM is made (write on a push, read on a pop), and the RAM's registered
// read data is loaded into the result registers. The result appears in the
// same cycle as busy falls, so a new request may be issued while the previous
// result is on the ports. A push into a full queue returns the full status and
// leaves the queue unchanged; a pop from an empty queue returns the empty status
// and a zero word. No clearing pass follows reset: the store is read at an
// entry no push wrote only on a pop from an empty queue, whose word is dropped.

module bounded_double_ended_queue_core import bdq_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_type,
   input  logic [WORD_BITS-1:0] req_item_value,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_status,
   output logic [WORD_BITS-1:0] rsp_popped_value,
   output logic [CNT_BITS-1:0]  rsp_fill_count,
   output logic                 rsp_is_empty,
   output logic                 rsp_is_full
);

   // Command bundle from the sequencer to the datapath.
   bdq_cmd_type cmd;

   // The controller owns the handshake and steps each request through its phases.
   bdq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // The datapath holds the ring pointers, the word store and the result registers.
   bdq_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_type         (req_type),
      .req_item_value   (req_item_value),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_popped_value (rsp_popped_value),
      .rsp_fill_count   (rsp_fill_count),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_is_full      (rsp_is_full)
   );

endmodule

>>> sim/bounded_double_ended_queue_core_tb.sv
// Self-checking testbench for bounded_double_ended_queue_core: directed and
// phased random requests checked against a behavioural ring-buffer predictor.
// Depends on bdq_pkg and the RTL of the block; needs no files or arguments.
`timescale 1ns / 1ps

module bounded_double_ended_queue_core_tb;
   import bdq_pkg::*;

   // The block takes a new item only once it is through with the last one, so even
   // with idling the run stays far below this bound unless something hangs.
   localparam int CYCLE_LIMIT  = 100000;
   localparam int RANDOM_ITEMS = 1150;
   // Accepted-item window in which the sender never idles.
   localparam int STEADY_FIRST = 300;
   localparam int STEADY_LAST  = 520;
   localparam logic [WORD_BITS-1:0] ALL_ONES = '1;

   // One request waiting to be driven. A set hold flag makes the sender wait
   // until every awaited result has come back before offering this item.
   typedef struct {
      logic [1:0]           kind;
      logic [WORD_BITS-1:0] word;
      bit                   hold;
   } deque_request_type;

   // The result the block should return for one accepted item.
   typedef struct {
      logic [1:0]           status;
      logic [WORD_BITS-1:0] word;
      logic [CNT_BITS-1:0]  fill;
      logic                 empty;
      logic                 full;
   } deque_answer_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [1:0]           req_type = REQ_PUSH_BACK;
   logic [WORD_BITS-1:0] req_item_value = '0;
   logic                 rsp_valid;
   logic [1:0]           rsp_status;
   logic [WORD_BITS-1:0] rsp_popped_value;
   logic [CNT_BITS-1:0]  rsp_fill_count;
   logic                 rsp_is_empty;
   logic                 rsp_is_full;

   deque_request_type request_backlog[$];
   deque_answer_type  awaited_results[$];

   // Predictor state: a ring of words with a head index and a fill count.
   logic [WORD_BITS-1:0] ring_words [DEPTH];
   int ring_head  = 0;
   int ring_count = 0;

   int error_count    = 0;
   int accepted_count = 0;
   int checked_count  = 0;
   int cycle_count    = 0;
   int full_rejects   = 0;
   int empty_pops     = 0;
   int peak_fill      = 0;

   bounded_double_ended_queue_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_item_value   (req_item_value),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_popped_value (rsp_popped_value),
      .rsp_fill_count   (rsp_fill_count),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_is_full      (rsp_is_full)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Applies one request to the predictor's ring and returns the result the
   // block must give for it. A push into a full ring and a pop from an empty
   // ring leave the ring as it was and return a zero word.
   function automatic deque_answer_type deque_apply(logic [1:0] kind,
                                                    logic [WORD_BITS-1:0] word);
      deque_answer_type answer;
      answer.status = STATUS_DONE;
      answer.word   = '0;
      if (kind == REQ_PUSH_BACK || kind == REQ_PUSH_FRONT) begin
         if (ring_count >= DEPTH) begin
            answer.status = STATUS_FULL;
            full_rejects++;
         end else if (kind == REQ_PUSH_BACK) begin
            ring_words[(ring_head + ring_count) % DEPTH] = word;
            ring_count++;
         end else begin
            ring_head = (ring_head + DEPTH - 1) % DEPTH;
            ring_words[ring_head] = word;
            ring_count++;
         end
      end else begin
         if (ring_count == 0) begin
            answer.status = STATUS_EMPTY_POP;
            empty_pops++;
         end else if (kind == REQ_POP_BACK) begin
            ring_count--;
            answer.word = ring_words[(ring_head + ring_count) % DEPTH];
         end else begin
            answer.word = ring_words[ring_head];
            ring_head = (ring_head + 1) % DEPTH;
            ring_count--;
         end
      end
      if (ring_count > peak_fill)
         peak_fill = ring_count;
      answer.fill  = ring_count[CNT_BITS-1:0];
      answer.empty = (ring_count == 0);
      answer.full  = (ring_count == DEPTH);
      return answer;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
      $display("MISMATCH at result %0d: %s expected 0x%0h, got 0x%0h",
               checked_count, field, want, got);
      error_count++;
   endtask

   task automatic queue_request(logic [1:0] kind, logic [WORD_BITS-1:0] word, bit hold);
      deque_request_type item;
      item.kind = kind;
      item.word = word;
      item.hold = hold;
      request_backlog.push_back(item);
   endtask

   // Driver. An item is taken at an edge where start is high and busy is
   // low; the values seen here are those from before the edge, so the
   // prediction uses exactly what the block captured. An item on offer is
   // never withdrawn, so idling is only decided when choosing a new one.
   always @(posedge clock) begin
      deque_answer_type answer;
      bit               offer;
      bit               presented;
      presented = 1'b0;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            answer = deque_apply(req_type, req_item_value);
            awaited_results.push_back(answer);
            void'(request_backlog.pop_front());
            accepted_count++;
         end else if (start) begin
            presented = 1'b1;
         end
         if (!presented) begin
            offer = (request_backlog.size() > 0);
            if (offer && request_backlog[0].hold && awaited_results.size() > 0)
               offer = 1'b0;
            if (offer && !(accepted_count >= STEADY_FIRST && accepted_count < STEADY_LAST)
                && $urandom_range(0, 99) < 12)
               offer = 1'b0;
            if (offer) begin
               start          <= 1'b1;
               req_type       <= request_backlog[0].kind;
               req_item_value <= request_backlog[0].word;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor. A result is on the ports for one cycle only and cannot be held
   // off, so it is checked at the edge that ends that cycle against the
   // oldest awaited result.
   always @(posedge clock) begin
      deque_answer_type want;
      if (!reset && rsp_valid) begin
         if (awaited_results.size() == 0) begin
            $display("MISMATCH: result with status 0x%0h arrived with nothing awaited",
                     rsp_status);
            error_count++;
         end else begin
            want = awaited_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(want.status), 32'(rsp_status));
            if (rsp_popped_value !== want.word)
               report_mismatch("popped value", 32'(want.word), 32'(rsp_popped_value));
            if (rsp_fill_count !== want.fill)
               report_mismatch("fill count", 32'(want.fill), 32'(rsp_fill_count));
            if (rsp_is_empty !== want.empty)
               report_mismatch("empty flag", 32'(want.empty), 32'(rsp_is_empty));
            if (rsp_is_full !== want.full)
               report_mismatch("full flag", 32'(want.full), 32'(rsp_is_full));
            checked_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results still awaited.",
                  cycle_count, awaited_results.size());
         $display("bounded_double_ended_queue_core verification failed");
         $finish;
      end
   end

   // Stimulus and end of run.
   initial begin
      int         mode;
      int         stretch;
      int         push_share;
      logic [1:0] kind;
      logic [WORD_BITS-1:0] word;
      int         pick;

      // Directed items: pops on an empty queue from both ends, extreme and
      // alternating words from both ends, a front push that wraps the head
      // below index zero and is then popped from the back, and the top bit.
      queue_request(REQ_POP_BACK,   ALL_ONES,               1'b0);
      queue_request(REQ_POP_FRONT,  '0,                     1'b0);
      queue_request(REQ_PUSH_BACK,  '0,                     1'b0);
      queue_request(REQ_PUSH_BACK,  ALL_ONES,               1'b0);
      queue_request(REQ_PUSH_FRONT, 32'hAAAA_AAAA,          1'b0);
      queue_request(REQ_PUSH_FRONT, 32'h5555_5555,          1'b0);
      queue_request(REQ_POP_FRONT,  '0,                     1'b0);
      queue_request(REQ_POP_BACK,   '0,                     1'b0);
      queue_request(REQ_POP_BACK,   '0,                     1'b0);
      queue_request(REQ_POP_FRONT,  '0,                     1'b0);
      queue_request(REQ_POP_FRONT,  ALL_ONES,               1'b0);
      queue_request(REQ_PUSH_FRONT, 32'h0000_0001,          1'b0);
      queue_request(REQ_POP_BACK,   '0,                     1'b0);
      queue_request(REQ_PUSH_BACK,  32'h8000_0000,          1'b0);
      queue_request(REQ_PUSH_FRONT, 32'h7FFF_FFFE,          1'b0);
      queue_request(REQ_POP_FRONT,  '0,                     1'b0);
      queue_request(REQ_POP_FRONT,  '0,                     1'b0);
      queue_request(REQ_POP_BACK,   '0,                     1'b0);

      // Random items in stretches that mostly fill, mostly drain or mix, so
      // the ring is driven to full and to empty many times and its indices
      // wrap in both directions. Pops carry random words, which must be
      // ignored. The first item and one in the middle make the sender drain the block.
      stretch = 0;
      mode    = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (stretch == 0) begin
            mode    = $urandom_range(0, 2);
            stretch = $urandom_range(20, 120);
         end
         stretch--;
         push_share = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
         if ($urandom_range(0, 99) < push_share)
            kind = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
         else
            kind = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
         pick = $urandom_range(0, 19);
         if (pick == 0)
            word = '0;
         else if (pick == 1)
            word = ALL_ONES;
         else
            word = $urandom();
         queue_request(kind, word, (n == 0 || n == RANDOM_ITEMS / 2));
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (request_backlog.size() > 0)
         @(posedge clock);
      while (awaited_results.size() > 0)
         @(posedge clock);
      // Keep the clock running so that a stray result would be seen.
      repeat (8) @(posedge clock);

      $display("Checked %0d results from %0d items: %0d rejected pushes, %0d empty pops.",
               checked_count, accepted_count, full_rejects, empty_pops);
      $display("Peak fill reached %0d of %0d words.", peak_fill, DEPTH);
      if (error_count == 0) begin
         $display("bounded_double_ended_queue_core verification clean");
      end else begin
         $display("bounded_double_ended_queue_core verification failed");
      end
      $finish;
   end

endmodule

>>> bounded_double_ended_queue_core.f
rtl/bdq_pkg.sv
rtl/bdq_ram.sv
rtl/bdq_ctrl.sv
rtl/bdq_datapath.sv
rtl/bounded_double_ended_queue_core.sv
sim/bounded_double_ended_queue_core_tb.sv
